// File: hw/rtl/msce_pkg.sv
`timescale 1ns / 1ps

package msce_pkg;

	// CRC standard selected by the mode register
	typedef enum logic [1:0] {
		MODE_CRC8      = 2'd0,
		MODE_CRC16_CCITT = 2'd1,
		MODE_CRC16_MODBUS = 2'd2,
		MODE_CRC32     = 2'd3
	} crc_mode_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_MODE = 2'd0,
		CFG_SEED = 2'd1,
		CFG_POLY = 2'd2,
		CFG_NONE = 2'd3
	} cfg_index_t;

	// Fixed generator polynomials
	localparam logic [15:0] POLY_CCITT       = 16'h1021;
	localparam logic [15:0] POLY_MODBUS_REFL = 16'hA001;
	localparam logic [31:0] POLY_CRC32_REFL  = 32'hEDB88320;

	// Reset values of the configuration registers and the running CRC
	localparam crc_mode_t   RESET_MODE = MODE_CRC32;
	localparam logic [31:0] RESET_SEED = 32'hFFFF_FFFF;
	localparam logic [7:0]  RESET_POLY = 8'h07;
	localparam logic [31:0] RESET_CRC  = 32'hFFFF_FFFF;

	// Input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
		logic       last;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic [31:0] crc_value;
		logic        is_last;
	} out_item_t;

	// Configuration as seen by the datapath
	typedef struct packed {
		crc_mode_t   mode;
		logic [31:0] seed;
		logic [7:0]  poly8;
	} cfg_t;

endpackage

// File: hw/rtl/msce_cfg.sv
`timescale 1ns / 1ps

module msce_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 cfg_ready,
	output msce_pkg::cfg_t       cfg
);

	msce_pkg::crc_mode_t mode_q;
	logic [31:0]         seed_q;
	logic [7:0]          poly_q;

	// Writes are always taken
	assign cfg_ready = 1'b1;

	// Register file; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= msce_pkg::RESET_MODE;
			seed_q <= msce_pkg::RESET_SEED;
			poly_q <= msce_pkg::RESET_POLY;
		end else if (cfg_valid) begin
			unique case (msce_pkg::cfg_index_t'(cfg_index))
				msce_pkg::CFG_MODE: mode_q <= msce_pkg::crc_mode_t'(cfg_data[1:0]);
				msce_pkg::CFG_SEED: seed_q <= cfg_data;
				msce_pkg::CFG_POLY: poly_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg.mode  = mode_q;
	assign cfg.seed  = seed_q;
	assign cfg.poly8 = poly_q;

endmodule

// File: hw/rtl/msce_fold.sv
`timescale 1ns / 1ps

module msce_fold (
	input  msce_pkg::cfg_t  cfg,
	input  logic [31:0]     crc_in,
	input  logic [7:0]      data_byte,
	output logic [31:0]     crc_next,
	output logic [31:0]     crc_result
);

	logic [7:0]  c8;
	logic [15:0] c16a;
	logic [15:0] c16b;
	logic [31:0] c32;

	// Eight bit steps of each standard, side by side
	always_comb begin
		c8   = crc_in[7:0] ^ data_byte;
		c16a = crc_in[15:0] ^ {data_byte, 8'h00};
		c16b = crc_in[15:0] ^ {8'h00, data_byte};
		c32  = crc_in ^ {24'h000000, data_byte};
		for (int k = 0; k < 8; k++) begin
			c8   = c8[7] ? ({c8[6:0], 1'b0} ^ cfg.poly8) : {c8[6:0], 1'b0};
			c16a = c16a[15] ? ({c16a[14:0], 1'b0} ^ msce_pkg::POLY_CCITT)
			                : {c16a[14:0], 1'b0};
			c16b = c16b[0] ? ({1'b0, c16b[15:1]} ^ msce_pkg::POLY_MODBUS_REFL)
			               : {1'b0, c16b[15:1]};
			c32  = c32[0] ? ({1'b0, c32[31:1]} ^ msce_pkg::POLY_CRC32_REFL)
			              : {1'b0, c32[31:1]};
		end
	end

	// Mode select; CRC-32 gets the final inversion on the result only
	always_comb begin
		unique case (cfg.mode)
			msce_pkg::MODE_CRC8: begin
				crc_next   = {24'h000000, c8};
				crc_result = {24'h000000, c8};
			end
			msce_pkg::MODE_CRC16_CCITT: begin
				crc_next   = {16'h0000, c16a};
				crc_result = {16'h0000, c16a};
			end
			msce_pkg::MODE_CRC16_MODBUS: begin
				crc_next   = {16'h0000, c16b};
				crc_result = {16'h0000, c16b};
			end
			default: begin
				crc_next   = c32;
				crc_result = ~c32;
			end
		endcase
	end

endmodule

// File: hw/rtl/multi_standard_crc_engine.sv
`timescale 1ns / 1ps

// Byte-wide CRC engine: CRC-8 (programmable polynomial), CRC-16/CCITT-FALSE,
// CRC-16/MODBUS and IEEE CRC-32, chosen by the mode register.
// Input channel: in_valid / in_stall carry one item (byte, first, last).
// An item with first set restarts from the seed register.
// Output channel: out_valid / out_stall carry one result item per input
// item: the finished CRC after that byte (CRC-32 inverted) and last echoed.
// Configuration: cfg_valid / cfg_ready with index 0 mode, 1 seed,
// 2 CRC-8 polynomial; ready is always high. Write only while idle.
// An accepted item is registered in the input stage, folded
// combinationally and registered in the result register.
// Throughput: one item per cycle while the output is not stalled; the
// combinational byte fold closes the running-CRC loop.
// Reset: registers return to mode CRC-32, seed all ones, polynomial 0x07,
// running CRC all ones, both stages empty.
// Stall: a stalled result holds on the output; the input stage still takes
// an item into its empty slot, then in_stall rises until the output drains.

module multi_standard_crc_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  msce_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output msce_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	msce_pkg::cfg_t     cfg;
	msce_pkg::in_item_t item_s1;
	logic               valid_s1;
	logic               advance;
	logic               load;
	logic [31:0]        running_crc_q;
	logic [31:0]        crc_in;
	logic [31:0]        crc_next;
	logic [31:0]        crc_result;

	msce_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cfg       (cfg)
	);

	// Handshake control
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_data;
		end
	end

	// Byte fold
	assign crc_in = item_s1.first ? cfg.seed : running_crc_q;

	msce_fold u_fold (
		.cfg        (cfg),
		.crc_in     (crc_in),
		.data_byte  (item_s1.data_byte),
		.crc_next   (crc_next),
		.crc_result (crc_result)
	);

	// Running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= msce_pkg::RESET_CRC;
		end else if (advance) begin
			running_crc_q <= crc_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data.crc_value <= crc_result;
			out_data.is_last   <= item_s1.last;
		end
	end

	// Checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid)
		else $error("input stalled with an empty input stage");

	a_crc8_upper_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cfg.mode == msce_pkg::MODE_CRC8) |=> running_crc_q[31:8] == 24'h000000)
		else $error("CRC-8 fold left upper running bits set");

	a_crc32_inverted: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cfg.mode == msce_pkg::MODE_CRC32) |=> out_data.crc_value == ~running_crc_q)
		else $error("CRC-32 result does not match the inverted running CRC");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !valid_s1) |=> !out_valid)
		else $error("result shown twice");

endmodule
